>>> sv/bes_pkg.sv
// ----------------------------------------------------------------------------
// bes_pkg
// Shared types, codes and type-size rules for the BSON element scanner.
// ----------------------------------------------------------------------------
package bes_pkg;

	localparam int unsigned MAX_DOC_BYTES = 65536;
	localparam int unsigned MAX_KEY_BYTES = 8;
	localparam int unsigned POS_W         = $clog2(MAX_DOC_BYTES) + 1;
	localparam int unsigned KPOS_W        = $clog2(MAX_KEY_BYTES + 1);
	localparam int unsigned MIN_DOC_BYTES = 5;

	// configuration register indexes
	localparam logic [0:0] CFG_SEARCH_KEY     = 1'b0;
	localparam logic [0:0] CFG_SEARCH_KEY_LEN = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_TYPE,
		PH_KEY,
		PH_LENGTH,
		PH_VALUE,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_END   = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_OVERRUN   = 3'd3,
		ST_UNKNOWN   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		SC_FIXED,
		SC_STRING,
		SC_BINARY,
		SC_DOC,
		SC_UNKNOWN
	} size_class_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       doc_start;
	} in_word_t;

	typedef struct packed {
		logic [15:0] element_index;
		logic [7:0]  element_type;
		logic        key_match;
		logic [15:0] element_offset;
		logic [15:0] value_offset;
		logic [15:0] value_length;
		logic        doc_done;
		status_t     status;
	} out_word_t;

	function automatic size_class_t size_class(input logic [7:0] t);
		size_class_t c;
		case (t) inside
			8'h01, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h10, 8'h11, 8'h12: c = SC_FIXED;
			8'h02, 8'h0D, 8'h0E: c = SC_STRING;
			8'h05:               c = SC_BINARY;
			8'h03, 8'h04:        c = SC_DOC;
			default:             c = SC_UNKNOWN;
		endcase
		return c;
	endfunction

	// value size of fixed-size types; zero for everything else
	function automatic logic [3:0] fixed_size(input logic [7:0] t);
		logic [3:0] n;
		case (t) inside
			8'h01, 8'h09, 8'h11, 8'h12: n = 4'd8;
			8'h07:                      n = 4'd12;
			8'h10:                      n = 4'd4;
			8'h08:                      n = 4'd1;
			default:                    n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

>>> sv/bes_scan.sv
// ----------------------------------------------------------------------------
// bes_scan
// Per-byte document walker: parse state and the record built from one byte.
// ----------------------------------------------------------------------------
module bes_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  bes_pkg::in_word_t  word,
	input  logic [63:0]        search_key,
	input  logic [3:0]         search_key_len,
	output logic               res_valid,
	output bes_pkg::out_word_t res
);
	import bes_pkg::*;

	phase_t              phase_q, phase_d, ph;
	logic [POS_W-1:0]    doc_len_q, doc_len_d, dlen;
	logic [POS_W-1:0]    byte_pos_q, byte_pos_d, pos;
	logic [7:0]          cur_type_q, cur_type_d, ctype;
	logic [KPOS_W-1:0]   key_pos_q, key_pos_d, kp;
	logic                mismatch_q, mismatch_d, mism;
	logic [31:0]         len_field_q, len_field_d, lfield;
	logic [POS_W-1:0]    val_rem_q, val_rem_d, vrem;
	logic [15:0]         elem_cnt_q, elem_cnt_d, ecnt;
	logic [POS_W-1:0]    elem_start_q, elem_start_d, estart;
	logic [POS_W-1:0]    val_start_q, val_start_d, vstart;

	logic                active;
	logic [7:0]          b;
	logic [POS_W-1:0]    last;
	logic [31:0]         lf;
	logic [33:0]         vlen;
	logic [POS_W-1:0]    vs;
	logic                m;
	size_class_t         cls;
	logic [3:0]          n;
	logic [POS_W-1:0]    rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			doc_len_q    <= '0;
			byte_pos_q   <= '0;
			cur_type_q   <= '0;
			key_pos_q    <= '0;
			mismatch_q   <= 1'b0;
			len_field_q  <= '0;
			val_rem_q    <= '0;
			elem_cnt_q   <= '0;
			elem_start_q <= '0;
			val_start_q  <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			doc_len_q    <= doc_len_d;
			byte_pos_q   <= byte_pos_d;
			cur_type_q   <= cur_type_d;
			key_pos_q    <= key_pos_d;
			mismatch_q   <= mismatch_d;
			len_field_q  <= len_field_d;
			val_rem_q    <= val_rem_d;
			elem_cnt_q   <= elem_cnt_d;
			elem_start_q <= elem_start_d;
			val_start_q  <= val_start_d;
		end
	end

	always_comb begin
		b = word.data_byte;
		// a start mark drops whatever document is in progress
		if (word.doc_start) begin
			ph     = PH_HEADER;
			dlen   = '0;
			pos    = '0;
			ctype  = '0;
			kp     = '0;
			mism   = 1'b0;
			lfield = '0;
			vrem   = '0;
			ecnt   = '0;
			estart = '0;
			vstart = '0;
		end else begin
			ph     = phase_q;
			dlen   = doc_len_q;
			pos    = byte_pos_q;
			ctype  = cur_type_q;
			kp     = key_pos_q;
			mism   = mismatch_q;
			lfield = len_field_q;
			vrem   = val_rem_q;
			ecnt   = elem_cnt_q;
			estart = elem_start_q;
			vstart = val_start_q;
		end
		active = word.doc_start || (ph != PH_IDLE && ph != PH_DONE);

		phase_d      = ph;
		doc_len_d    = dlen;
		byte_pos_d   = pos;
		cur_type_d   = ctype;
		key_pos_d    = kp;
		mismatch_d   = mism;
		len_field_d  = lfield;
		val_rem_d    = vrem;
		elem_cnt_d   = ecnt;
		elem_start_d = estart;
		val_start_d  = vstart;

		res_valid = 1'b0;
		res       = '0;
		res.element_index = ecnt;

		last = dlen - POS_W'(1);
		lf   = '0;
		vlen = '0;
		vs   = pos + POS_W'(1);
		m    = mism;
		cls  = size_class(ctype);
		n    = fixed_size(ctype);
		rem  = '0;

		if (active) begin
			byte_pos_d = pos + POS_W'(1);
			case (ph)
				PH_HEADER: begin
					lf = lfield | ({24'b0, b} << {pos[1:0], 3'b000});
					len_field_d = lf;
					if (pos >= POS_W'(3)) begin
						if (lf > 32'(MAX_DOC_BYTES)) begin
							res_valid          = 1'b1;
							res.element_offset = pos[15:0];
							res.doc_done       = 1'b1;
							res.status         = ST_TOO_LARGE;
							phase_d            = PH_DONE;
						end else if (lf < 32'(MIN_DOC_BYTES)) begin
							res_valid          = 1'b1;
							res.element_offset = pos[15:0];
							res.doc_done       = 1'b1;
							res.status         = ST_BAD_END;
							phase_d            = PH_DONE;
						end else begin
							doc_len_d = lf[POS_W-1:0];
							phase_d   = PH_TYPE;
						end
					end
				end
				PH_TYPE: begin
					if (pos == last || b == 8'h00) begin
						// last offset must be the trailing zero; an early zero is bad
						res_valid          = 1'b1;
						res.element_offset = pos[15:0];
						res.doc_done       = 1'b1;
						res.status         = (pos == last && b == 8'h00) ? ST_OK : ST_BAD_END;
						phase_d            = PH_DONE;
					end else begin
						cur_type_d   = b;
						elem_start_d = pos;
						key_pos_d    = '0;
						mismatch_d   = 1'b0;
						phase_d      = PH_KEY;
					end
				end
				default: begin
					if (pos >= last) begin
						res_valid          = 1'b1;
						res.element_offset = pos[15:0];
						res.doc_done       = 1'b1;
						res.status         = ST_OVERRUN;
						phase_d            = PH_DONE;
					end else begin
						case (ph)
							PH_KEY: begin
								if (b != 8'h00) begin
									if (!mism && kp < search_key_len &&
										kp < KPOS_W'(MAX_KEY_BYTES) &&
										b == search_key[kp[2:0]*8 +: 8])
										key_pos_d = kp + KPOS_W'(1);
									else
										mismatch_d = 1'b1;
								end else begin
									m           = mism || (kp != search_key_len);
									mismatch_d  = m;
									val_start_d = vs;
									if (cls == SC_STRING || cls == SC_BINARY || cls == SC_DOC) begin
										key_pos_d   = '0;
										len_field_d = '0;
										phase_d     = PH_LENGTH;
									end else if ((POS_W+1)'(vs) + (POS_W+1)'(n) >
										(POS_W+1)'(last)) begin
										res_valid          = 1'b1;
										res.element_offset = pos[15:0];
										res.doc_done       = 1'b1;
										res.status         = ST_OVERRUN;
										phase_d            = PH_DONE;
									end else begin
										res_valid          = 1'b1;
										res.element_type   = ctype;
										res.key_match      = !m;
										res.element_offset = estart[15:0];
										res.value_offset   = vs[15:0];
										res.value_length   = 16'(n);
										res.status = (cls == SC_UNKNOWN) ? ST_UNKNOWN : ST_OK;
										elem_cnt_d = ecnt + 16'd1;
										val_rem_d  = POS_W'(n);
										phase_d    = (n != 4'd0) ? PH_VALUE : PH_TYPE;
									end
								end
							end
							PH_LENGTH: begin
								lf = lfield | ({24'b0, b} << {kp[1:0], 3'b000});
								len_field_d = lf;
								key_pos_d   = kp + KPOS_W'(1);
								if (kp >= KPOS_W'(3)) begin
									case (cls)
										SC_STRING: vlen = 34'd4 + 34'(lf);
										SC_BINARY: vlen = 34'd5 + 34'(lf);
										default:   vlen = 34'(lf);
									endcase
									if (vlen < 34'd4 || 34'(vstart) + vlen > 34'(last)) begin
										res_valid          = 1'b1;
										res.element_offset = pos[15:0];
										res.doc_done       = 1'b1;
										res.status         = ST_OVERRUN;
										phase_d            = PH_DONE;
									end else begin
										res_valid          = 1'b1;
										res.element_type   = ctype;
										res.key_match      = !mism;
										res.element_offset = estart[15:0];
										res.value_offset   = vstart[15:0];
										res.value_length   = vlen[15:0];
										res.status         = ST_OK;
										elem_cnt_d = ecnt + 16'd1;
										// length word already consumed
										rem        = vlen[POS_W-1:0] - POS_W'(4);
										val_rem_d  = rem;
										phase_d    = (rem != '0) ? PH_VALUE : PH_TYPE;
									end
								end
							end
							PH_VALUE: begin
								rem = (vrem != '0) ? vrem - POS_W'(1) : vrem;
								val_rem_d = rem;
								if (rem == '0)
									phase_d = PH_TYPE;
							end
							default: begin
								phase_d = ph;
							end
						endcase
					end
				end
			endcase
		end
	end

endmodule

>>> sv/bson_element_scanner_top.sv
// ----------------------------------------------------------------------------
// bson_element_scanner_top
// BSON top-level element scanner with search-key match.
// ----------------------------------------------------------------------------
// Takes one document byte per word and sustains one word per cycle while the
// skid is empty. Each byte is registered in stage 1, then walked through the
// parse state; a record, if any, reaches out_data via the output register. A
// two-deep output buffer (output register plus skid) lets the input keep
// flowing while a record waits on out_ready. Write search_key and
// search_key_len only while the scanner is idle.
module bson_element_scanner_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bes_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bes_pkg::out_word_t out_data,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [63:0]        cfg_wdata
);
	import bes_pkg::*;

	logic        [63:0] search_key_q;
	logic        [3:0]  search_key_len_q;

	in_word_t           word_s1;
	logic               valid_s1;
	logic               adv_s1;

	logic               res_valid;
	out_word_t          res;
	logic               push;

	out_word_t          out_q;
	logic               out_valid_q;
	out_word_t          skid_q;
	logic               skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_key_q     <= '0;
			search_key_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEARCH_KEY:     search_key_q     <= cfg_wdata;
				CFG_SEARCH_KEY_LEN: search_key_len_q <= cfg_wdata[3:0];
				default:            search_key_q     <= search_key_q;
			endcase
		end
	end

	// stage 1 advances whenever the output buffer has room for one record
	assign adv_s1   = valid_s1 && !skid_valid_q;
	assign in_ready = !valid_s1 || adv_s1;
	assign push     = adv_s1 && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			word_s1 <= in_data;
	end

	bes_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (adv_s1),
		.word           (word_s1),
		.search_key     (search_key_q),
		.search_key_len (search_key_len_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			// drain skid first; stage 1 is held while skid is full
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a record while output register is empty");

	a_elem_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.doc_done) |->
			(out_data.status == ST_OK || out_data.status == ST_UNKNOWN))
		else $error("element record carries a document-level status");

	a_final_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.doc_done) |->
			(out_data.element_type == 8'h00 && !out_data.key_match &&
			 out_data.value_offset == 16'h0000 && out_data.value_length == 16'h0000))
		else $error("final record has nonzero element fields");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !adv_s1)
		else $error("stage 1 advanced with output buffer full");
`endif

endmodule
